FILE: hw/rtl/dmq_pkg.sv
// Shared types and constants for the drop-oldest message queue.
// Used by dmq_mem, dmq_ctrl and drop_oldest_message_queue; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmq_pkg;

    localparam int TAG_W       = 16;
    localparam int SIZE_W      = 16;
    localparam int BYTES_W     = 22;
    localparam int DEPTH_CFG_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 22;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd1;

    localparam logic [DEPTH_CFG_W-1:0] MAX_DEPTH_RESET = 7'd64;
    localparam logic [BYTES_W-1:0]     MAX_BYTES_RESET = 22'd262144;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_DROP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_TOO_BIG = 2'd1,
        STAT_EMPTY   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_POP_WAIT,
        FSM_PUT_CHECK,
        FSM_DROP_WAIT
    } fsm_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic [DEPTH_CFG_W-1:0] max_depth;
        logic [BYTES_W-1:0]     max_bytes;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmq_mem.sv
// Descriptor store: one write port, one read port, registered read data.
// Depends on dmq_pkg for the entry type and the port control struct.
`timescale 1ns / 1ps
`default_nettype none

module dmq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              clk,
    input  wire dmq_pkg::mem_ctl_t ctl,
    input  wire logic [AW-1:0]     raddr,
    input  wire logic [AW-1:0]     waddr,
    input  wire dmq_pkg::entry_t   wdata,
    output dmq_pkg::entry_t        rdata
);
    import dmq_pkg::*;

    entry_t mem [DEPTH];

    // Write the tail entry
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read the head entry into a registered output
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dmq_ctrl.sv
// Queue sequencer: head, length and byte total, admission and drop loop.
// Depends on dmq_pkg; drives the read and write ports of dmq_mem.
`timescale 1ns / 1ps
`default_nettype none

module dmq_ctrl #(
    parameter int QUEUE_DEPTH = 64,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dmq_pkg::cfg_t               cfg,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  op,
    input  wire logic [dmq_pkg::TAG_W-1:0]   msg_tag,
    input  wire logic [dmq_pkg::SIZE_W-1:0]  msg_size,
    output dmq_pkg::mem_ctl_t                mem_ctl,
    output logic [IDX_W-1:0]                 mem_raddr,
    output logic [IDX_W-1:0]                 mem_waddr,
    output dmq_pkg::entry_t                  mem_wdata,
    input  wire dmq_pkg::entry_t             mem_rdata,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [CNT_W-1:0]                 dropped_count,
    output logic [dmq_pkg::TAG_W-1:0]        out_tag,
    output logic [dmq_pkg::SIZE_W-1:0]       out_size,
    output logic [CNT_W-1:0]                 queue_length,
    output logic [dmq_pkg::BYTES_W-1:0]      queue_bytes
);
    import dmq_pkg::*;

    localparam int DW    = (CNT_W > DEPTH_CFG_W) ? CNT_W : DEPTH_CFG_W;
    localparam int SUM_W = CNT_W + 1;

    fsm_t                state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [CNT_W-1:0]    drop_reg, drop_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [CNT_W-1:0]    res_drop_reg, res_drop_next;
    logic [TAG_W-1:0]    res_tag_reg, res_tag_next;
    logic [SIZE_W-1:0]   res_size_reg, res_size_next;

    logic [DW-1:0]       depth_cfg;
    logic [DW-1:0]       depth_lim;
    logic                at_limit;
    logic                bytes_over;
    logic                too_big;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail_idx;
    logic [IDX_W-1:0]    head_inc;

    // Clamp the depth limit to 1 .. QUEUE_DEPTH
    always_comb
    begin
        depth_cfg = DW'(cfg.max_depth);
        if (depth_cfg == '0)
        begin
            depth_lim = DW'(1);
        end
        else if (depth_cfg > DW'(QUEUE_DEPTH))
        begin
            depth_lim = DW'(QUEUE_DEPTH);
        end
        else
        begin
            depth_lim = depth_cfg;
        end
    end

    // Admission checks: limits against the held put, size against the offered message
    assign at_limit   = DW'(count_reg) >= depth_lim;
    assign bytes_over = ({1'b0, bytes_reg} + (BYTES_W + 1)'(size_reg))
                        > {1'b0, cfg.max_bytes};
    assign too_big    = BYTES_W'(msg_size) > cfg.max_bytes;

    // Circular index arithmetic
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail_idx = tail_sum[IDX_W-1:0];
        head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    // Next state, memory access and result
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        bytes_next    = bytes_reg;
        drop_next     = drop_reg;
        tag_next      = tag_reg;
        size_next     = size_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        res_drop_next = res_drop_reg;
        res_tag_next  = res_tag_reg;
        res_size_next = res_size_reg;
        mem_ctl       = '0;
        mem_waddr     = tail_idx;
        mem_wdata     = '{tag: tag_reg, size: size_reg};

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    res_drop_next = '0;
                    res_tag_next  = '0;
                    res_size_next = '0;
                    status_next   = STAT_OK;
                    unique case (op_t'(op))
                        OP_PUT:
                        begin
                            if (too_big)
                            begin
                                status_next = STAT_TOO_BIG;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                tag_next   = msg_tag;
                                size_next  = msg_size;
                                drop_next  = '0;
                                state_next = FSM_PUT_CHECK;
                            end
                        end
                        OP_GET, OP_DROP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                state_next    = FSM_POP_WAIT;
                            end
                        end
                        OP_NONE:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            FSM_POP_WAIT:
            begin
                res_tag_next  = mem_rdata.tag;
                res_size_next = mem_rdata.size;
                bytes_next    = bytes_reg - BYTES_W'(mem_rdata.size);
                count_next    = count_reg - 1'b1;
                head_next     = head_inc;
                done_next     = 1'b1;
                state_next    = FSM_IDLE;
            end

            FSM_PUT_CHECK:
            begin
                if ((count_reg != '0) && (at_limit || bytes_over))
                begin
                    // Drop the head: fetch its size first
                    mem_ctl.rd_en = 1'b1;
                    state_next    = FSM_DROP_WAIT;
                end
                else
                begin
                    // Append at the tail and report
                    mem_ctl.wr_en = 1'b1;
                    count_next    = count_reg + 1'b1;
                    bytes_next    = bytes_reg + BYTES_W'(size_reg);
                    res_drop_next = drop_reg;
                    done_next     = 1'b1;
                    state_next    = FSM_IDLE;
                end
            end

            FSM_DROP_WAIT:
            begin
                bytes_next = bytes_reg - BYTES_W'(mem_rdata.size);
                count_next = count_reg - 1'b1;
                head_next  = head_inc;
                drop_next  = drop_reg + 1'b1;
                state_next = FSM_PUT_CHECK;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            bytes_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            bytes_reg <= bytes_next;
            done_reg  <= done_next;
        end
    end

    // Held put and result payload
    always_ff @(posedge clk)
    begin
        drop_reg     <= drop_next;
        tag_reg      <= tag_next;
        size_reg     <= size_next;
        status_reg   <= status_next;
        res_drop_reg <= res_drop_next;
        res_tag_reg  <= res_tag_next;
        res_size_reg <= res_size_next;
    end

    assign mem_raddr     = head_reg;
    assign busy          = (state_reg != FSM_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign dropped_count = res_drop_reg;
    assign out_tag       = res_tag_reg;
    assign out_size      = res_size_reg;
    assign queue_length  = count_reg;
    assign queue_bytes   = bytes_reg;

    // Length never exceeds the store
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue length beyond store depth");

    // An empty queue holds no bytes
    a_empty_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (bytes_reg == '0))
        else $error("byte total nonzero on empty queue");

    // Head read and tail write never share a cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("read and write in same cycle");

    // A drop read always returns to the admission check
    a_drop_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_DROP_WAIT) |=> (state_reg == FSM_PUT_CHECK))
        else $error("drop loop left early");

    // A successful put leaves at least one entry
    a_put_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == FSM_PUT_CHECK) && mem_ctl.wr_en) |=> (count_reg != '0))
        else $error("put left queue empty");

endmodule

`default_nettype wire

FILE: hw/rtl/drop_oldest_message_queue.sv
// Top level of the drop-oldest message queue: configuration registers,
// sequencer and descriptor store. Depends on dmq_pkg, dmq_ctrl and dmq_mem.
//
// Usage:
//   Pulse start with op/msg_tag/msg_size while busy is low; the transaction
//   is taken at that clock edge. Exactly one result per transaction appears
//   on status/dropped_count/out_tag/out_size/queue_length/queue_bytes for
//   one cycle, marked by done. The receiver cannot stall; every result is
//   taken in the cycle it is shown.
//   A rejected put, an empty get or drop-head and the unused op finish
//   straight from idle; a get or drop-head reads the head, then pops it; a
//   put runs the admission check, a head drop per failed check, then the
//   append. Each drop is a head read from the store then its removal,
//   because the size of the dropped entry is only known after the synchronous read.
//   Items are handled one at a time; busy stays high until done is set, and
//   a new transaction may be taken in the cycle done is high.
//   Configuration (cfg_write/cfg_index/cfg_data) is taken at any edge with
//   cfg_write high; index 0 is max_depth, 1 is max_bytes, others ignored.
//   Reset empties the queue and restores max_depth 64, max_bytes 262144;
//   store contents are not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module drop_oldest_message_queue #(
    parameter int QUEUE_DEPTH = 64,
    localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [dmq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dmq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     op,
    input  wire logic [dmq_pkg::TAG_W-1:0]      msg_tag,
    input  wire logic [dmq_pkg::SIZE_W-1:0]     msg_size,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [CNT_W-1:0]                    dropped_count,
    output logic [dmq_pkg::TAG_W-1:0]           out_tag,
    output logic [dmq_pkg::SIZE_W-1:0]          out_size,
    output logic [CNT_W-1:0]                    queue_length,
    output logic [dmq_pkg::BYTES_W-1:0]         queue_bytes
);
    import dmq_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    mem_ctl_t mem_ctl;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] mem_waddr;
    entry_t   mem_wdata;
    entry_t   mem_rdata;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_DEPTH: cfg_next.max_depth = cfg_data[DEPTH_CFG_W-1:0];
                CFG_MAX_BYTES: cfg_next.max_bytes = cfg_data[BYTES_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_depth <= MAX_DEPTH_RESET;
            cfg_reg.max_bytes <= MAX_BYTES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dmq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .msg_tag       (msg_tag),
        .msg_size      (msg_size),
        .mem_ctl       (mem_ctl),
        .mem_raddr     (mem_raddr),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata),
        .done          (done),
        .status        (status),
        .dropped_count (dropped_count),
        .out_tag       (out_tag),
        .out_size      (out_size),
        .queue_length  (queue_length),
        .queue_bytes   (queue_bytes)
    );

    dmq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .raddr (mem_raddr),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: tb/drop_oldest_message_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for drop_oldest_message_queue: directed and random put, get and
// drop-head traffic, each result checked against a shadow copy of the queue.
// Depends on dmq_pkg and the drop_oldest_message_queue RTL.

module drop_oldest_message_queue_tb;
    import dmq_pkg::*;

    localparam int DEPTH        = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 2 + 2 * DEPTH;

    // Indexes past the register list; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        op_t               op;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } request_t;

    typedef struct packed {
        status_t                status;
        logic [DEPTH_CFG_W-1:0] dropped;
        logic [TAG_W-1:0]       tag;
        logic [SIZE_W-1:0]      size;
        logic [DEPTH_CFG_W-1:0] length;
        logic [BYTES_W-1:0]     bytes;
    } report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             op = '0;
    logic [TAG_W-1:0]       msg_tag = '0;
    logic [SIZE_W-1:0]      msg_size = '0;
    logic                   done;
    logic [1:0]             status;
    logic [DEPTH_CFG_W-1:0] dropped_count;
    logic [TAG_W-1:0]       out_tag;
    logic [SIZE_W-1:0]      out_size;
    logic [DEPTH_CFG_W-1:0] queue_length;
    logic [BYTES_W-1:0]     queue_bytes;

    // Shadow copy of the queue and its limits
    logic [TAG_W-1:0]       sh_tags [DEPTH];
    logic [SIZE_W-1:0]      sh_sizes [DEPTH];
    int                     sh_head = 0;
    int                     sh_count = 0;
    int                     sh_bytes = 0;
    logic [DEPTH_CFG_W-1:0] sh_max_depth = MAX_DEPTH_RESET;
    logic [BYTES_W-1:0]     sh_max_bytes = MAX_BYTES_RESET;

    report_t                awaited_reports [$];
    int                     error_count = 0;
    int                     cycle_count = 0;
    int                     idle_pct = 0;

    drop_oldest_message_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .op(op),
        .msg_tag(msg_tag),
        .msg_size(msg_size),
        .done(done),
        .status(status),
        .dropped_count(dropped_count),
        .out_tag(out_tag),
        .out_size(out_size),
        .queue_length(queue_length),
        .queue_bytes(queue_bytes)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Remove the head of the shadow queue
    function automatic void pop_shadow_head();
        sh_bytes = sh_bytes - int'(sh_sizes[sh_head]);
        sh_count = sh_count - 1;
        sh_head  = (sh_head + 1) % DEPTH;
    endfunction

    // Apply one transaction to the shadow queue and return the result it should give
    function automatic report_t shadow_queue_step(input request_t rq);
        report_t rp;
        int      lim;
        int      slot;
        rp.status  = STAT_OK;
        rp.dropped = '0;
        rp.tag     = '0;
        rp.size    = '0;
        case (rq.op)
            OP_PUT:
            begin
                if (int'(rq.size) > int'(sh_max_bytes))
                    rp.status = STAT_TOO_BIG;
                else
                begin
                    lim = int'(sh_max_depth);
                    if (lim < 1)
                        lim = 1;
                    if (lim > DEPTH)
                        lim = DEPTH;
                    // drop from the head until the new message fits both limits
                    while (sh_count > 0 && (sh_count >= lim ||
                           sh_bytes + int'(rq.size) > int'(sh_max_bytes)))
                    begin
                        pop_shadow_head();
                        rp.dropped = rp.dropped + 7'd1;
                    end
                    slot = (sh_head + sh_count) % DEPTH;
                    sh_tags[slot]  = rq.tag;
                    sh_sizes[slot] = rq.size;
                    sh_count = sh_count + 1;
                    sh_bytes = sh_bytes + int'(rq.size);
                end
            end
            OP_GET, OP_DROP:
            begin
                if (sh_count == 0)
                    rp.status = STAT_EMPTY;
                else
                begin
                    rp.tag  = sh_tags[sh_head];
                    rp.size = sh_sizes[sh_head];
                    pop_shadow_head();
                end
            end
            default: ;
        endcase
        rp.length = DEPTH_CFG_W'(sh_count);
        rp.bytes  = BYTES_W'(sh_bytes);
        return rp;
    endfunction

    // Check each result against the oldest awaited one
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && done)
        begin
            if (awaited_reports.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: status %0d tag %h size %h len %0d bytes %0d",
                             status, out_tag, out_size, queue_length, queue_bytes);
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (status !== want.status || dropped_count !== want.dropped ||
                    out_tag !== want.tag || out_size !== want.size ||
                    queue_length !== want.length || queue_bytes !== want.bytes)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $write("mismatch: expected st %0d drop %0d tag %h size %h ",
                               want.status, want.dropped, want.tag, want.size);
                        $write("len %0d bytes %0d, got st %0d drop %0d tag %h size %h ",
                               want.length, want.bytes, status, dropped_count,
                               out_tag, out_size);
                        $display("len %0d bytes %0d", queue_length, queue_bytes);
                    end
                end
            end
        end
    end

    // Offer one transaction, wait until busy is low again, then idle at random
    task automatic send_item(input op_t o, input logic [TAG_W-1:0] tag,
                             input logic [SIZE_W-1:0] size);
        request_t rq;
        int       gap;
        rq.op   = o;
        rq.tag  = tag;
        rq.size = size;
        start    <= 1'b1;
        op       <= o;
        msg_tag  <= tag;
        msg_size <= size;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        awaited_reports.push_back(shadow_queue_step(rq));
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off until every awaited result has arrived
    task automatic wait_for_reports();
        start <= 1'b0;
        @(posedge clk);
        while (awaited_reports.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_MAX_DEPTH: sh_max_depth = data[DEPTH_CFG_W-1:0];
            CFG_MAX_BYTES: sh_max_bytes = data[BYTES_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Reprogram both limits once the queue is quiet
    task automatic set_limits(input logic [CFG_DATA_W-1:0] depth_data,
                              input logic [CFG_DATA_W-1:0] bytes_data);
        wait_for_reports();
        write_register(CFG_MAX_DEPTH, depth_data);
        write_register(CFG_MAX_BYTES, bytes_data);
    endtask

    function automatic request_t random_request();
        request_t rq;
        int       r;
        r = $urandom_range(99);
        rq.op  = (r < 55) ? OP_PUT : (r < 78) ? OP_GET : (r < 95) ? OP_DROP : OP_NONE;
        rq.tag = TAG_W'($urandom);
        r = $urandom_range(99);
        if (r < 25)
            rq.size = SIZE_W'($urandom_range(15));
        else if (r < 50)
            rq.size = SIZE_W'($urandom_range(1023));
        else if (r < 75)
            rq.size = SIZE_W'($urandom);
        else if (r < 85)
            rq.size = '0;
        else if (r < 95)
            rq.size = 16'hFFFF;
        else
            rq.size = SIZE_W'($urandom_range(8191));
        return rq;
    endfunction

    task automatic run_random_phase(input logic [CFG_DATA_W-1:0] depth_data,
                                    input logic [CFG_DATA_W-1:0] bytes_data,
                                    input int pct, input int budget);
        request_t rq;
        int       sent;
        int       k;
        set_limits(depth_data, bytes_data);
        idle_pct = pct;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(199) == 0)
            begin
                // fill to the depth limit with small messages, then put one of the largest size
                for (k = 0; k < DEPTH; k++)
                    send_item(OP_PUT, TAG_W'($urandom), SIZE_W'($urandom_range(1023)));
                send_item(OP_PUT, TAG_W'($urandom), 16'hFFFF);
                sent += DEPTH + 1;
            end
            else
            begin
                if ($urandom_range(99) < 2)
                    wait_for_reports();
                rq = random_request();
                send_item(rq.op, rq.tag, rq.size);
                sent++;
            end
        end
    endtask

    // Get, drop-head and the unused op on an empty queue
    task automatic test_empty_queue();
        send_item(OP_GET, 16'hFFFF, 16'hFFFF);
        send_item(OP_DROP, 16'h1234, 16'h0001);
        send_item(OP_NONE, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_put_and_pop();
        send_item(OP_PUT, 16'hFFFF, 16'hFFFF);
        send_item(OP_PUT, 16'h0000, 16'h0000);
        send_item(OP_NONE, 16'h5A5A, 16'hA5A5);
        send_item(OP_GET, 16'h0000, 16'h0000);
        send_item(OP_DROP, 16'h0000, 16'h0000);
        send_item(OP_GET, 16'h0000, 16'h0000);
    endtask

    // Reject oversize puts, drop for bytes, and a zero byte limit
    task automatic test_byte_limit();
        set_limits(22'd64, 22'd1000);
        send_item(OP_PUT, 16'h0001, 16'd1001);
        send_item(OP_PUT, 16'h0002, 16'd1000);
        send_item(OP_PUT, 16'h0003, 16'd1);
        send_item(OP_PUT, 16'h0004, 16'd999);
        set_limits(22'd64, 22'd0);
        send_item(OP_PUT, 16'h0005, 16'd0);
        send_item(OP_PUT, 16'h0006, 16'd1);
    endtask

    // A depth of zero acts as one
    task automatic test_depth_limit();
        set_limits(22'd0, 22'd262144);
        send_item(OP_PUT, 16'h0010, 16'd10);
        send_item(OP_PUT, 16'h0011, 16'd11);
        set_limits(22'd2, 22'd262144);
        send_item(OP_PUT, 16'h0012, 16'd12);
        send_item(OP_PUT, 16'h0013, 16'd13);
    endtask

    // Lower the depth limit under a held queue, and write the spare indexes
    task automatic test_lowered_limits();
        set_limits(22'd64, 22'd262144);
        send_item(OP_PUT, 16'h0020, 16'd20);
        send_item(OP_PUT, 16'h0021, 16'd21);
        send_item(OP_PUT, 16'h0022, 16'd22);
        set_limits(22'h3FFF81, 22'h3FFFFF);
        send_item(OP_PUT, 16'h0023, 16'd23);
        wait_for_reports();
        write_register(CFG_SPARE_2, 22'd0);
        write_register(CFG_SPARE_3, 22'd0);
        send_item(OP_PUT, 16'h0024, 16'd5);
    endtask

    task automatic test_random_traffic();
        run_random_phase(22'd64, 22'd262144, 0, 400);
        run_random_phase(22'd4, 22'd5000, 58, 300);
        run_random_phase(22'd127, 22'd65535, 7, 400);
        run_random_phase(22'd1, 22'h3FFFFF, 0, 200);
        run_random_phase(22'd0, 22'd0, 58, 150);
        run_random_phase(CFG_DATA_W'($urandom_range(127)),
                         CFG_DATA_W'($urandom_range(200000)), 7, 300);
        run_random_phase(22'd64, 22'd4194240, 0, 250);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_put_and_pop();
        test_byte_limit();
        test_depth_limit();
        test_lowered_limits();
        test_random_traffic();
        // settle, then allow for any stray late result
        wait_for_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && awaited_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/dmq_pkg.sv
hw/rtl/dmq_mem.sv
hw/rtl/dmq_ctrl.sv
hw/rtl/drop_oldest_message_queue.sv
tb/drop_oldest_message_queue_tb.sv
